// File: hdl/mstt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot timer table: shared definitions
// Operation and status codes, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mstt_pkg;

   // Field widths of the request and response beats.
   localparam int FUNC_W     = 2;
   localparam int SLOT_W     = 4;
   localparam int IVL_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int ACTIVE_W   = 5;

   // At most this many expiries are reported for one tick.
   localparam int MAX_RESULTS = 16;
   localparam int HIT_IDX_W   = $clog2(MAX_RESULTS);
   localparam int HIT_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Operation codes carried by req_func.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_ADD     = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_DELETE  = 2'd3
   } func_type;

   // Status codes carried by rsp_status.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_BAD_IVL  = 3'd2,
      STAT_UNUSED   = 3'd3,
      STAT_INACTIVE = 3'd4
   } status_type;

   // Source of the slot number noted for a single-beat response.
   typedef enum logic [1:0] {
      SLOT_ZERO  = 2'd0,
      SLOT_INDEX = 2'd1,
      SLOT_PTR   = 2'd2
   } slot_sel_type;

   // Controller states.
   typedef enum logic [2:0] {
      CS_IDLE     = 3'd0,
      CS_DISPATCH = 3'd1,
      CS_ADD_SCAN = 3'd2,
      CS_TICK_WALK = 3'd3,
      CS_TICK_DRAIN = 3'd4,
      CS_TICK_EMIT = 3'd5,
      CS_RESP     = 3'd6
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         ptr_step;
      logic         tick_step;
      logic         add_commit;
      logic         restart_commit;
      logic         delete_commit;
      logic         note;
      status_type   note_status;
      slot_sel_type note_slot;
      logic         emit_note;
      logic         emit_quiet;
      logic         emit_hit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     full;
      logic     ivl_zero;
      logic     idx_hit;
      logic     ptr_free;
      logic     ptr_last;
      logic     hit_none;
      logic     emit_last;
   } dp_stat_type;

endpackage

// File: hdl/multi_slot_software_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot timer table
// A table of SLOTS timer slots handled one request beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request beat on the req_ ports while busy is low; the
//   beat is taken at that edge and busy stays high until the last response.
//   req_func selects tick, add, restart or delete.
//   Each response beat is shown on the rsp_ ports for one cycle under
//   rsp_strobe; rsp_last marks the final beat of a request. The receiver
//   cannot stall, so beats are simply taken as they come.
// Sequence:
//   Restart, delete and a rejected add answer from the dispatch state
//   through the response state. An accepted add scans for the lowest
//   free slot, one slot per cycle, then answers through the response state.
//   A tick walks every slot through the counter memories, one slot per
//   cycle behind a registered read, then gives its expiry beats back to
//   back, at most 16 beats. The next request may start in the cycle
//   that shows the last beat.
// Reset:
//   A synchronous reset empties the table; counters and targets of free
//   slots are never used, so the memories need no clearing pass.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table #(
   parameter int SLOTS        = 16,
   parameter int TICKS_PER_MS = 1,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mstt_pkg::FUNC_W-1:0]        req_func,
   input  logic [mstt_pkg::SLOT_W-1:0]        req_slot_index,
   input  logic [mstt_pkg::IVL_W-1:0]         req_interval_ms,
   input  logic                               req_repeat_req,
   output logic                               rsp_strobe,
   output logic [mstt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mstt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                               rsp_fired,
   output logic [mstt_pkg::ACTIVE_W-1:0]      rsp_active_count,
   output logic                               rsp_last
);

   mstt_pkg::ctl_cmd_type cmd;
   mstt_pkg::dp_stat_type stat;

   // Sequencer.
   mstt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Slot storage and response formation.
   mstt_dpath #(
      .SLOTS        (SLOTS),
      .TICKS_PER_MS (TICKS_PER_MS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .req_interval_ms  (req_interval_ms),
      .req_repeat_req   (req_repeat_req),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_fired        (rsp_fired),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last)
   );

endmodule

// File: hdl/mstt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot timer table: controller
// Sequences one request at a time: dispatch, free-slot scan for add, slot
// walk for tick, and the response beats.
// ----------------------------------------------------------------------------
module mstt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mstt_pkg::dp_stat_type stat,
   output mstt_pkg::ctl_cmd_type cmd
);

   mstt_pkg::ctl_state_type state_ff;
   mstt_pkg::ctl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mstt_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         mstt_pkg::CS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = mstt_pkg::CS_DISPATCH;
            end
         end
         mstt_pkg::CS_DISPATCH: begin
            unique case (stat.func)
               mstt_pkg::FUNC_TICK: begin
                  state_in = mstt_pkg::CS_TICK_WALK;
               end
               mstt_pkg::FUNC_ADD: begin
                  // The full check comes before the interval check.
                  priority if (stat.full) begin
                     cmd.note        = 1'b1;
                     cmd.note_status = mstt_pkg::STAT_FULL;
                     cmd.note_slot   = mstt_pkg::SLOT_ZERO;
                     state_in        = mstt_pkg::CS_RESP;
                  end else if (stat.ivl_zero) begin
                     cmd.note        = 1'b1;
                     cmd.note_status = mstt_pkg::STAT_BAD_IVL;
                     cmd.note_slot   = mstt_pkg::SLOT_ZERO;
                     state_in        = mstt_pkg::CS_RESP;
                  end else begin
                     state_in = mstt_pkg::CS_ADD_SCAN;
                  end
               end
               mstt_pkg::FUNC_RESTART: begin
                  cmd.note      = 1'b1;
                  cmd.note_slot = mstt_pkg::SLOT_INDEX;
                  if (stat.idx_hit) begin
                     cmd.restart_commit = 1'b1;
                     cmd.note_status    = mstt_pkg::STAT_OK;
                  end else begin
                     cmd.note_status = mstt_pkg::STAT_UNUSED;
                  end
                  state_in = mstt_pkg::CS_RESP;
               end
               mstt_pkg::FUNC_DELETE: begin
                  cmd.note      = 1'b1;
                  cmd.note_slot = mstt_pkg::SLOT_INDEX;
                  if (stat.idx_hit) begin
                     cmd.delete_commit = 1'b1;
                     cmd.note_status   = mstt_pkg::STAT_OK;
                  end else begin
                     cmd.note_status = mstt_pkg::STAT_INACTIVE;
                  end
                  state_in = mstt_pkg::CS_RESP;
               end
               default: begin
                  state_in = mstt_pkg::CS_IDLE;
               end
            endcase
         end
         mstt_pkg::CS_ADD_SCAN: begin
            // One slot per cycle until the lowest free slot is found or the last slot is passed.
            priority if (stat.ptr_free) begin
               cmd.add_commit  = 1'b1;
               cmd.note        = 1'b1;
               cmd.note_status = mstt_pkg::STAT_OK;
               cmd.note_slot   = mstt_pkg::SLOT_PTR;
               state_in        = mstt_pkg::CS_RESP;
            end else if (stat.ptr_last) begin
               cmd.note        = 1'b1;
               cmd.note_status = mstt_pkg::STAT_FULL;
               cmd.note_slot   = mstt_pkg::SLOT_ZERO;
               state_in        = mstt_pkg::CS_RESP;
            end else begin
               cmd.ptr_step = 1'b1;
            end
         end
         mstt_pkg::CS_TICK_WALK: begin
            cmd.tick_step = 1'b1;
            if (stat.ptr_last) begin
               state_in = mstt_pkg::CS_TICK_DRAIN;
            end
         end
         mstt_pkg::CS_TICK_DRAIN: begin
            // The last slot finishes its update here.
            state_in = mstt_pkg::CS_TICK_EMIT;
         end
         mstt_pkg::CS_TICK_EMIT: begin
            if (stat.hit_none) begin
               cmd.emit_quiet = 1'b1;
               state_in       = mstt_pkg::CS_IDLE;
            end else begin
               cmd.emit_hit = 1'b1;
               if (stat.emit_last) begin
                  state_in = mstt_pkg::CS_IDLE;
               end
            end
         end
         mstt_pkg::CS_RESP: begin
            cmd.emit_note = 1'b1;
            state_in      = mstt_pkg::CS_IDLE;
         end
         default: begin
            state_in = mstt_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/mstt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot timer table: datapath
// Slot flags, the counter and target memories, the two-stage tick update,
// the expiry list and the response registers.
// ----------------------------------------------------------------------------
module mstt_dpath #(
   parameter int SLOTS        = 16,
   parameter int TICKS_PER_MS = 1,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mstt_pkg::ctl_cmd_type              cmd,
   output mstt_pkg::dp_stat_type              stat,
   input  logic [mstt_pkg::FUNC_W-1:0]        req_func,
   input  logic [mstt_pkg::SLOT_W-1:0]        req_slot_index,
   input  logic [mstt_pkg::IVL_W-1:0]         req_interval_ms,
   input  logic                               req_repeat_req,
   output logic                               rsp_strobe,
   output logic [mstt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mstt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic                               rsp_fired,
   output logic [mstt_pkg::ACTIVE_W-1:0]      rsp_active_count,
   output logic                               rsp_last
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam int TPM_W  = $clog2(TICKS_PER_MS + 1);
   localparam int PROD_W = mstt_pkg::IVL_W + TPM_W;
   localparam int EXT_W  = (PROD_W > COUNT_WIDTH) ? PROD_W : COUNT_WIDTH;
   localparam int SW     = mstt_pkg::SLOT_W;

   // Latched request.
   mstt_pkg::func_type           func_ff;
   logic [SW-1:0]                idx_ff;
   logic [mstt_pkg::IVL_W-1:0]   ivl_ff;
   logic                         rep_ff;

   // Control state.
   logic [IDX_W-1:0]             ptr_ff, ptr_in;
   logic [SLOTS-1:0]             en_ff, en_in;
   logic [SLOTS-1:0]             per_ff, per_in;
   logic [TOT_W-1:0]             tot_ff, tot_in;
   logic                         s2_valid_ff;
   logic [IDX_W-1:0]             s2_idx_ff;
   logic [mstt_pkg::HIT_CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [mstt_pkg::HIT_IDX_W-1:0] emit_ptr_ff, emit_ptr_in;
   logic                         rsp_strobe_ff;

   // Memories and their registered read data.
   logic [COUNT_WIDTH-1:0]       cnt_mem [SLOTS];
   logic [COUNT_WIDTH-1:0]       tgt_mem [SLOTS];
   logic [COUNT_WIDTH-1:0]       cnt_rd_ff;
   logic [COUNT_WIDTH-1:0]       tgt_rd_ff;

   // Expiry list and response payload.
   logic [SW-1:0]                hit_list_ff [mstt_pkg::MAX_RESULTS];
   mstt_pkg::status_type         res_status_ff;
   logic [SW-1:0]                res_slot_ff;
   logic [mstt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [SW-1:0]                rsp_slot_ff;
   logic                         rsp_fired_ff;
   logic [mstt_pkg::ACTIVE_W-1:0] rsp_active_ff;
   logic                         rsp_last_ff;

   // Widened views for index checks and masked outputs.
   logic [IDX_W+SW-1:0]          idx_wide;
   logic [IDX_W-1:0]             idx_sel;
   logic                         idx_valid;
   logic [IDX_W+SW-1:0]          ptr_wide;
   logic [SW-1:0]                ptr_slot;
   logic [IDX_W+SW-1:0]          s2_wide;
   logic [SW-1:0]                s2_slot;
   logic [TOT_W+mstt_pkg::ACTIVE_W-1:0] tot_wide;

   // Target computation.
   logic [PROD_W-1:0]            prod;
   logic [EXT_W-1:0]             prod_ext;
   logic [COUNT_WIDTH-1:0]       tgt_new;

   // Tick update stage.
   logic                         s2_act;
   logic                         s2_fire;
   logic [COUNT_WIDTH-1:0]       cnt_inc;

   // Memory write port.
   logic                         cnt_we;
   logic                         tgt_we;
   logic [IDX_W-1:0]             mem_addr;
   logic [COUNT_WIDTH-1:0]       cnt_wdata;

   assign idx_wide  = {{IDX_W{1'b0}}, idx_ff};
   assign idx_sel   = idx_wide[IDX_W-1:0];
   assign idx_valid = (idx_wide < (IDX_W + SW)'(SLOTS));
   assign ptr_wide  = {{SW{1'b0}}, ptr_ff};
   assign ptr_slot  = ptr_wide[SW-1:0];
   assign s2_wide   = {{SW{1'b0}}, s2_idx_ff};
   assign s2_slot   = s2_wide[SW-1:0];
   assign tot_wide  = {{mstt_pkg::ACTIVE_W{1'b0}}, tot_ff};

   // Target is the interval in ticks, saturated to the counter width.
   assign prod     = PROD_W'(ivl_ff) * PROD_W'(TICKS_PER_MS);
   assign prod_ext = EXT_W'(prod);
   assign tgt_new  = (prod_ext > EXT_W'({COUNT_WIDTH{1'b1}})) ?
                     {COUNT_WIDTH{1'b1}} : prod_ext[COUNT_WIDTH-1:0];

   // Second stage of the tick walk: advance the slot read last cycle.
   assign cnt_inc = cnt_rd_ff + COUNT_WIDTH'(1);
   assign s2_act  = s2_valid_ff && en_ff[s2_idx_ff] && (tgt_rd_ff != '0);
   assign s2_fire = s2_act && (cnt_inc >= tgt_rd_ff);

   // Status toward the controller.
   always_comb begin
      stat.func      = func_ff;
      stat.full      = (tot_ff >= TOT_W'(SLOTS - 1));
      stat.ivl_zero  = (ivl_ff == '0);
      stat.idx_hit   = idx_valid && en_ff[idx_sel];
      stat.ptr_free  = !en_ff[ptr_ff];
      stat.ptr_last  = (ptr_ff == IDX_W'(SLOTS - 1));
      stat.hit_none  = (hit_cnt_ff == '0);
      stat.emit_last = ((mstt_pkg::HIT_CNT_W'(emit_ptr_ff) + mstt_pkg::HIT_CNT_W'(1))
                        == hit_cnt_ff);
   end

   // Memory write port selection; the sources never overlap in time.
   always_comb begin
      cnt_we    = 1'b0;
      tgt_we    = 1'b0;
      mem_addr  = ptr_ff;
      cnt_wdata = '0;
      priority if (s2_act) begin
         cnt_we    = 1'b1;
         mem_addr  = s2_idx_ff;
         cnt_wdata = s2_fire ? '0 : cnt_inc;
      end else if (cmd.add_commit) begin
         cnt_we   = 1'b1;
         tgt_we   = 1'b1;
         mem_addr = ptr_ff;
      end else if (cmd.restart_commit) begin
         cnt_we   = 1'b1;
         mem_addr = idx_sel;
      end else begin
         cnt_we = 1'b0;
      end
   end

   // Counter and target memories with registered reads at the walk pointer.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[mem_addr] <= cnt_wdata;
      end
      if (tgt_we) begin
         tgt_mem[mem_addr] <= tgt_new;
      end
      cnt_rd_ff <= cnt_mem[ptr_ff];
      tgt_rd_ff <= tgt_mem[ptr_ff];
   end

   // Next values of the slot flags, active total and pointers.
   always_comb begin
      en_in       = en_ff;
      per_in      = per_ff;
      tot_in      = tot_ff;
      ptr_in      = ptr_ff;
      hit_cnt_in  = hit_cnt_ff;
      emit_ptr_in = emit_ptr_ff;
      if (cmd.load) begin
         ptr_in      = '0;
         hit_cnt_in  = '0;
         emit_ptr_in = '0;
      end
      if (cmd.ptr_step || cmd.tick_step) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end
      if (s2_fire) begin
         if (!per_ff[s2_idx_ff]) begin
            en_in[s2_idx_ff] = 1'b0;
            if (tot_ff != '0) begin
               tot_in = tot_ff - TOT_W'(1);
            end
         end
         if (hit_cnt_ff < mstt_pkg::HIT_CNT_W'(mstt_pkg::MAX_RESULTS)) begin
            hit_cnt_in = hit_cnt_ff + mstt_pkg::HIT_CNT_W'(1);
         end
      end
      if (cmd.add_commit) begin
         en_in[ptr_ff]  = 1'b1;
         per_in[ptr_ff] = rep_ff;
         tot_in         = tot_ff + TOT_W'(1);
      end
      if (cmd.delete_commit) begin
         en_in[idx_sel]  = 1'b0;
         per_in[idx_sel] = 1'b0;
         if (tot_ff != '0) begin
            tot_in = tot_ff - TOT_W'(1);
         end
      end
      if (cmd.emit_hit) begin
         emit_ptr_in = emit_ptr_ff + mstt_pkg::HIT_IDX_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= '0;
         per_ff        <= '0;
         tot_ff        <= '0;
         ptr_ff        <= '0;
         s2_valid_ff   <= 1'b0;
         hit_cnt_ff    <= '0;
         emit_ptr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         en_ff         <= en_in;
         per_ff        <= per_in;
         tot_ff        <= tot_in;
         ptr_ff        <= ptr_in;
         s2_valid_ff   <= cmd.tick_step;
         hit_cnt_ff    <= hit_cnt_in;
         emit_ptr_ff   <= emit_ptr_in;
         rsp_strobe_ff <= cmd.emit_note || cmd.emit_quiet || cmd.emit_hit;
      end
   end

   // Request capture, walk stage index and expiry list.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= mstt_pkg::func_type'(req_func);
         idx_ff  <= req_slot_index;
         ivl_ff  <= req_interval_ms;
         rep_ff  <= req_repeat_req;
      end
      s2_idx_ff <= ptr_ff;
      if (s2_fire && (hit_cnt_ff < mstt_pkg::HIT_CNT_W'(mstt_pkg::MAX_RESULTS))) begin
         hit_list_ff[hit_cnt_ff[mstt_pkg::HIT_IDX_W-1:0]] <= s2_slot;
      end
   end

   // Noted result of a single-beat response.
   always_ff @(posedge clock) begin
      if (cmd.note) begin
         res_status_ff <= cmd.note_status;
         unique case (cmd.note_slot)
            mstt_pkg::SLOT_INDEX: res_slot_ff <= idx_ff;
            mstt_pkg::SLOT_PTR:   res_slot_ff <= ptr_slot;
            default:              res_slot_ff <= '0;
         endcase
      end
   end

   // Response beat registers; the active count is always the final total.
   always_ff @(posedge clock) begin
      priority if (cmd.emit_hit) begin
         rsp_status_ff <= mstt_pkg::STAT_OK;
         rsp_slot_ff   <= hit_list_ff[emit_ptr_ff];
         rsp_fired_ff  <= 1'b1;
         rsp_last_ff   <= stat.emit_last;
      end else if (cmd.emit_quiet) begin
         rsp_status_ff <= mstt_pkg::STAT_OK;
         rsp_slot_ff   <= '0;
         rsp_fired_ff  <= 1'b0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit_note) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_fired_ff  <= 1'b0;
         rsp_last_ff   <= 1'b1;
      end else begin
         rsp_last_ff <= rsp_last_ff;
      end
      rsp_active_ff <= tot_wide[mstt_pkg::ACTIVE_W-1:0];
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_active_count = rsp_active_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-slot timer table
// Drives tick, add, restart and delete beats into the table and keeps a
// shadow copy of every slot. Each accepted request is turned into the
// response beats the table should give, and every response beat is checked
// field by field against the oldest one still awaited.
// ----------------------------------------------------------------------------
module tb;

   localparam int SLOTS          = 16;
   localparam int TICKS_PER_MS   = 1;
   localparam int COUNT_WIDTH    = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 40;
   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 1);

   // One response beat as the table should present it.
   typedef struct {
      mstt_pkg::status_type           status;
      logic [mstt_pkg::SLOT_W-1:0]    slot;
      logic                           fired;
      logic [mstt_pkg::ACTIVE_W-1:0]  active;
      logic                           last;
   } rsp_beat_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [mstt_pkg::FUNC_W-1:0]    req_func;
   logic [mstt_pkg::SLOT_W-1:0]    req_slot_index;
   logic [mstt_pkg::IVL_W-1:0]     req_interval_ms;
   logic                           req_repeat_req;
   logic                           rsp_strobe;
   logic [mstt_pkg::STATUS_W-1:0]  rsp_status;
   logic [mstt_pkg::SLOT_W-1:0]    rsp_slot;
   logic                           rsp_fired;
   logic [mstt_pkg::ACTIVE_W-1:0]  rsp_active_count;
   logic                           rsp_last;

   // Shadow copy of the timer slots.
   logic                          shadow_en  [SLOTS];
   logic                          shadow_per [SLOTS];
   logic [COUNT_WIDTH-1:0]        shadow_tgt [SLOTS];
   logic [COUNT_WIDTH-1:0]        shadow_cnt [SLOTS];
   logic [mstt_pkg::ACTIVE_W-1:0] shadow_total;

   rsp_beat_type awaited_beats[$];
   int        error_count  = 0;
   int        quiet_cycles = 0;
   bit        idle_enable  = 1'b1;

   multi_slot_software_timer_table #(
      .SLOTS        (SLOTS),
      .TICKS_PER_MS (TICKS_PER_MS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .req_interval_ms  (req_interval_ms),
      .req_repeat_req   (req_repeat_req),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_fired        (rsp_fired),
      .rsp_active_count (rsp_active_count),
      .rsp_last         (rsp_last)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic push_beat(input mstt_pkg::status_type status, input int slot,
                            input logic fired, input logic last);
      rsp_beat_type beat;
      beat.status = status;
      beat.slot   = mstt_pkg::SLOT_W'(slot);
      beat.fired  = fired;
      beat.active = shadow_total;
      beat.last   = last;
      awaited_beats.push_back(beat);
   endtask

   // Applies one request to the shadow table and queues the beats it causes.
   task automatic step_timer_table(input mstt_pkg::func_type func,
                                   input logic [mstt_pkg::SLOT_W-1:0] idx,
                                   input logic [mstt_pkg::IVL_W-1:0] ivl, input logic rep);
      int          hit_slot [mstt_pkg::MAX_RESULTS];
      int          hit_count;
      int          free_slot;
      logic [31:0] target;
      hit_count = 0;
      free_slot = -1;
      case (func)
         mstt_pkg::FUNC_TICK: begin
            // Every active slot advances, lowest first; expiries are collected.
            for (int s = 0; s < SLOTS; s++) begin
               if (shadow_en[s] && shadow_tgt[s] != '0) begin
                  shadow_cnt[s] = shadow_cnt[s] + 1'b1;
                  if (shadow_cnt[s] >= shadow_tgt[s]) begin
                     shadow_cnt[s] = '0;
                     if (!shadow_per[s]) begin
                        shadow_en[s] = 1'b0;
                        if (shadow_total != '0) shadow_total--;
                     end
                     if (hit_count < mstt_pkg::MAX_RESULTS) begin
                        hit_slot[hit_count] = s;
                        hit_count++;
                     end
                  end
               end
            end
            // The count in each beat is the one after the whole tick.
            if (hit_count == 0) begin
               push_beat(mstt_pkg::STAT_OK, 0, 1'b0, 1'b1);
            end else begin
               for (int h = 0; h < hit_count; h++)
                  push_beat(mstt_pkg::STAT_OK, hit_slot[h], 1'b1, h == hit_count - 1);
            end
         end
         mstt_pkg::FUNC_ADD: begin
            // The full check comes before the interval check.
            if (shadow_total >= SLOTS - 1) begin
               push_beat(mstt_pkg::STAT_FULL, 0, 1'b0, 1'b1);
            end else if (ivl == '0) begin
               push_beat(mstt_pkg::STAT_BAD_IVL, 0, 1'b0, 1'b1);
            end else begin
               for (int s = SLOTS - 1; s >= 0; s--)
                  if (!shadow_en[s]) free_slot = s;
               if (free_slot < 0) begin
                  push_beat(mstt_pkg::STAT_FULL, 0, 1'b0, 1'b1);
               end else begin
                  target = 32'(ivl) * 32'(TICKS_PER_MS);
                  if (target > COUNT_MAX) target = COUNT_MAX;
                  shadow_en[free_slot]  = 1'b1;
                  shadow_per[free_slot] = rep;
                  shadow_tgt[free_slot] = COUNT_WIDTH'(target);
                  shadow_cnt[free_slot] = '0;
                  shadow_total++;
                  push_beat(mstt_pkg::STAT_OK, free_slot, 1'b0, 1'b1);
               end
            end
         end
         mstt_pkg::FUNC_RESTART: begin
            if (int'(idx) >= SLOTS || !shadow_en[idx] || shadow_tgt[idx] == '0) begin
               push_beat(mstt_pkg::STAT_UNUSED, idx, 1'b0, 1'b1);
            end else begin
               shadow_cnt[idx] = '0;
               push_beat(mstt_pkg::STAT_OK, idx, 1'b0, 1'b1);
            end
         end
         default: begin
            if (int'(idx) >= SLOTS || !shadow_en[idx]) begin
               push_beat(mstt_pkg::STAT_INACTIVE, idx, 1'b0, 1'b1);
            end else begin
               shadow_en[idx]  = 1'b0;
               shadow_per[idx] = 1'b0;
               shadow_tgt[idx] = '0;
               shadow_cnt[idx] = '0;
               if (shadow_total != '0) shadow_total--;
               push_beat(mstt_pkg::STAT_OK, idx, 1'b0, 1'b1);
            end
         end
      endcase
   endtask

   // Request acceptance, response checking and the watchdog, all at the rising edge.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset) begin
         // Responses first: a request taken at this edge cannot answer yet.
         if (rsp_strobe) begin
            if (awaited_beats.size() == 0) begin
               report_mismatch($sformatf("response beat with none awaited, slot %0d",
                                         rsp_slot));
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_slot !== want.slot)
                  report_mismatch($sformatf("slot %0d, expected %0d", rsp_slot, want.slot));
               if (rsp_fired !== want.fired)
                  report_mismatch($sformatf("fired %0d, expected %0d",
                                            rsp_fired, want.fired));
               if (rsp_active_count !== want.active)
                  report_mismatch($sformatf("active count %0d, expected %0d",
                                            rsp_active_count, want.active));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
            end
         end
         if (start && !busy)
            step_timer_table(mstt_pkg::func_type'(req_func), req_slot_index,
                             req_interval_ms, req_repeat_req);
         if ((start && !busy) || rsp_strobe)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // Sends one request beat, with random idle cycles ahead of it.
   task automatic send_beat(input mstt_pkg::func_type func, input int idx, input int ivl,
                            input logic rep);
      @(negedge clock);
      while (idle_enable && $urandom_range(0, 99) < 19) begin
         start = 1'b0;
         @(negedge clock);
      end
      start           = 1'b1;
      req_func        = func;
      req_slot_index  = mstt_pkg::SLOT_W'(idx);
      req_interval_ms = mstt_pkg::IVL_W'(ivl);
      req_repeat_req  = rep;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Mostly short intervals so timers expire often, with the edges mixed in.
   function automatic int pick_interval();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return 0;
      if (r < 70) return $urandom_range(1, 6);
      if (r < 85) return $urandom_range(7, 40);
      if (r < 95) return $urandom_range(0, 65535);
      return 65535;
   endfunction

   // Mostly an active slot, so restart and delete do real work.
   function automatic int pick_slot();
      int base;
      int s;
      base = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 99) < 75 && shadow_total != '0) begin
         for (int k = 0; k < SLOTS; k++) begin
            s = (base + k) % SLOTS;
            if (shadow_en[s]) return s;
         end
      end
      return $urandom_range(0, 15);
   endfunction

   // Sends one random request; the weights are percentages of add, tick and
   // restart, and delete takes the rest.
   task automatic send_random(input int add_pct, input int tick_pct, input int restart_pct);
      int                 r;
      mstt_pkg::func_type func;
      r = $urandom_range(0, 99);
      if (r < add_pct)                               func = mstt_pkg::FUNC_ADD;
      else if (r < add_pct + tick_pct)               func = mstt_pkg::FUNC_TICK;
      else if (r < add_pct + tick_pct + restart_pct) func = mstt_pkg::FUNC_RESTART;
      else                                           func = mstt_pkg::FUNC_DELETE;
      send_beat(func, pick_slot(), pick_interval(), $urandom_range(0, 1));
   endtask

   // Quiet tick, rejected and accepted adds, restart of a used and an unused
   // slot, delete of an unused slot, and a one-shot timer that fires and goes away.
   task automatic test_basic_ops();
      send_beat(mstt_pkg::FUNC_TICK,    0,  0,     1'b0);
      send_beat(mstt_pkg::FUNC_ADD,     0,  0,     1'b1);
      send_beat(mstt_pkg::FUNC_ADD,     0,  1,     1'b0);
      send_beat(mstt_pkg::FUNC_ADD,     15, 65535, 1'b1);
      send_beat(mstt_pkg::FUNC_RESTART, 1,  0,     1'b0);
      send_beat(mstt_pkg::FUNC_RESTART, 15, 65535, 1'b1);
      send_beat(mstt_pkg::FUNC_DELETE,  14, 0,     1'b0);
      send_beat(mstt_pkg::FUNC_TICK,    15, 65535, 1'b1);
   endtask

   // Fills the table to its limit, tries adds against the full table, then
   // lets most slots expire in a single tick.
   task automatic test_full_table();
      for (int k = 0; k < SLOTS - 2; k++)
         send_beat(mstt_pkg::FUNC_ADD, 0, 1, k[0]);
      send_beat(mstt_pkg::FUNC_ADD, 0, 5, 1'b1);
      send_beat(mstt_pkg::FUNC_ADD, 0, 0, 1'b0);
      send_beat(mstt_pkg::FUNC_TICK, 0, 0, 1'b0);
   endtask

   task automatic test_random_mix();
      for (int k = 0; k < 180; k++)
         send_random(30, 40, 15);
   endtask

   // A long run with the request side never idle.
   task automatic test_back_to_back();
      idle_enable = 1'b0;
      for (int k = 0; k < 120; k++)
         send_random(30, 40, 15);
      idle_enable = 1'b1;
   endtask

   // Pushes the table toward full, then drains it again.
   task automatic test_fill_and_drain();
      for (int k = 0; k < 50; k++)
         send_random(60, 20, 10);
      for (int k = 0; k < 50; k++)
         send_random(10, 20, 10);
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = mstt_pkg::FUNC_TICK;
      req_slot_index  = '0;
      req_interval_ms = '0;
      req_repeat_req  = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         shadow_en[s]  = 1'b0;
         shadow_per[s] = 1'b0;
         shadow_tgt[s] = '0;
         shadow_cnt[s] = '0;
      end
      shadow_total = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_full_table();
      test_random_mix();
      test_back_to_back();
      test_fill_and_drain();

      @(negedge clock);
      start = 1'b0;
      // The watchdog ends the run if awaited beats never come.
      while (awaited_beats.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
